>>> hdl/pmbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page mode bitmap blitter package
// Shared screen geometry defaults and request codes.
// ----------------------------------------------------------------------------
package pmbb_pkg;

  localparam int PMBB_COLUMNS = 128;
  localparam int PMBB_PAGES   = 8;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_BLIT  = 2'd1;
  localparam logic [1:0] REQ_BYTE  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

endpackage

>>> hdl/pmbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single port RAM
// Generic single port memory with one access per cycle and registered read.
// ----------------------------------------------------------------------------
module pmbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/page_mode_bitmap_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page mode bitmap blitter
// Monochrome page framebuffer with clear, blit, bitmap word merge and read.
// ----------------------------------------------------------------------------
// A word is accepted at a rising edge where start is high and busy is low;
// req_type_i selects clear, start blit, bitmap word or read. Start blit and a
// bitmap word that arrives with no blit active finish at the accept edge.
// A bitmap word passes the placement state, then a read and a write of the
// single port framebuffer RAM for each of the up to two pages it touches.
// A read keeps busy high through its request and response states; its result
// is on read_data_o and echo_index_o while done_o is high, exactly one cycle,
// in the response state. The receiver cannot stall, so nothing waits on it.
// A clear writes zero to every one of the SCREEN_COLUMNS*SCREEN_PAGES RAM
// entries (1024 by default), one per cycle, and keeps busy high until the last
// one is written. After reset the same clearing pass runs before the first word is taken.
// ----------------------------------------------------------------------------
module page_mode_bitmap_blitter
  import pmbb_pkg::*;
#(
  parameter int SCREEN_COLUMNS = PMBB_COLUMNS,
  parameter int SCREEN_PAGES   = PMBB_PAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type_i,
  input  logic signed [8:0] pos_x_i,
  input  logic signed [8:0] pos_y_i,
  input  logic [7:0]        bmp_width_i,
  input  logic [7:0]        bmp_height_i,
  input  logic              invert_i,
  input  logic [7:0]        src_byte_i,
  input  logic [9:0]        read_index_i,
  output logic              done_o,
  output logic [7:0]        read_data_o,
  output logic [9:0]        echo_index_o
);

  localparam int FbSize = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int AW     = $clog2(FbSize);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_CALC  = 4'd2;
  localparam logic [3:0] ST_RD0   = 4'd3;
  localparam logic [3:0] ST_WR0   = 4'd4;
  localparam logic [3:0] ST_RD1   = 4'd5;
  localparam logic [3:0] ST_WR1   = 4'd6;
  localparam logic [3:0] ST_RREQ  = 4'd7;
  localparam logic [3:0] ST_RRESP = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     clr_ptr_q, clr_ptr_d;
  logic signed [8:0] origin_col_q, origin_col_d;
  logic signed [8:0] origin_row_q, origin_row_d;
  logic [7:0]        cols_q, cols_d;
  logic [4:0]        pages_q, pages_d;
  logic              invert_q, invert_d;
  logic [7:0]        col_cnt_q, col_cnt_d;
  logic [4:0]        page_cnt_q, page_cnt_d;
  logic              active_q, active_d;

  logic [7:0]        byte_q, byte_d;
  logic [AW-1:0]     addr0_q, addr0_d;
  logic [AW-1:0]     addr1_q, addr1_d;
  logic [7:0]        bits0_q, bits0_d;
  logic [7:0]        bits1_q, bits1_d;
  logic              v1_q, v1_d;
  logic [9:0]        read_idx_q, read_idx_d;
  logic              rd_ok_q, rd_ok_d;

  logic              accept;
  logic signed [9:0] col_sum;
  logic signed [9:0] row_sum;
  logic signed [6:0] pg0;
  logic signed [6:0] pg1;
  logic              col_ok;
  logic              pg0_ok;
  logic              pg1_ok;
  logic              v0;
  logic              v1;
  logic [2:0]        off;
  logic [15:0]       shifted;
  logic [8:0]        col_nxt;
  logic [5:0]        page_nxt;

  logic              ram_en;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign col_sum = {origin_col_q[8], origin_col_q} + $signed({2'b00, col_cnt_q});
  assign row_sum = {origin_row_q[8], origin_row_q} + $signed({2'b00, page_cnt_q, 3'b000});
  assign pg0     = row_sum[9:3];
  assign pg1     = pg0 + 7'sd1;
  assign off     = row_sum[2:0];
  assign col_ok  = !col_sum[9] && ({1'b0, col_sum[8:0]} < 10'(SCREEN_COLUMNS));
  assign pg0_ok  = !pg0[6] && ({1'b0, pg0[5:0]} < 7'(SCREEN_PAGES));
  assign pg1_ok  = !pg1[6] && ({1'b0, pg1[5:0]} < 7'(SCREEN_PAGES));
  assign v0      = col_ok && pg0_ok;
  assign v1      = col_ok && pg1_ok && (off != 3'd0);
  assign shifted = {8'h00, byte_q} << off;
  assign col_nxt  = {1'b0, col_cnt_q} + 9'd1;
  assign page_nxt = {1'b0, page_cnt_q} + 6'd1;

  always_comb begin
    state_d      = state_q;
    clr_ptr_d    = clr_ptr_q;
    origin_col_d = origin_col_q;
    origin_row_d = origin_row_q;
    cols_d       = cols_q;
    pages_d      = pages_q;
    invert_d     = invert_q;
    col_cnt_d    = col_cnt_q;
    page_cnt_d   = page_cnt_q;
    active_d     = active_q;
    byte_d       = byte_q;
    addr0_d      = addr0_q;
    addr1_d      = addr1_q;
    bits0_d      = bits0_q;
    bits1_d      = bits1_q;
    v1_d         = v1_q;
    read_idx_d   = read_idx_q;
    rd_ok_d      = rd_ok_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_CLEAR: begin
              clr_ptr_d = '0;
              state_d   = ST_CLEAR;
            end
            REQ_BLIT: begin
              origin_col_d = pos_x_i;
              origin_row_d = pos_y_i;
              cols_d       = bmp_width_i;
              pages_d      = bmp_height_i[7:3];
              invert_d     = invert_i;
              col_cnt_d    = '0;
              page_cnt_d   = '0;
              active_d     = (bmp_width_i != 8'd0) && (bmp_height_i[7:3] != 5'd0);
            end
            REQ_BYTE: begin
              if (active_q) begin
                byte_d  = src_byte_i ^ {8{invert_q}};
                state_d = ST_CALC;
              end
            end
            default: begin
              read_idx_d = read_index_i;
              rd_ok_d    = ({22'd0, read_index_i} < 32'(FbSize));
              state_d    = ST_RREQ;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_ptr_d = clr_ptr_q + AW'(1);
        if (clr_ptr_q == AW'(FbSize - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        addr0_d = AW'(AW'(pg0[5:0]) * AW'(SCREEN_COLUMNS) + AW'(col_sum[8:0]));
        addr1_d = AW'(AW'(pg1[5:0]) * AW'(SCREEN_COLUMNS) + AW'(col_sum[8:0]));
        bits0_d = shifted[7:0];
        bits1_d = shifted[15:8];
        v1_d    = v1;
        if (col_nxt >= {1'b0, cols_q}) begin
          col_cnt_d = '0;
          if (page_nxt >= {1'b0, pages_q}) begin
            page_cnt_d = '0;
            active_d   = 1'b0;
          end else begin
            page_cnt_d = page_nxt[4:0];
          end
        end else begin
          col_cnt_d = col_nxt[7:0];
        end
        if (v0) begin
          state_d = ST_RD0;
        end else if (v1) begin
          state_d = ST_RD1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD0: begin
        state_d = ST_WR0;
      end
      ST_WR0: begin
        state_d = v1_q ? ST_RD1 : ST_IDLE;
      end
      ST_RD1: begin
        state_d = ST_WR1;
      end
      ST_WR1: begin
        state_d = ST_IDLE;
      end
      ST_RREQ: begin
        state_d = ST_RRESP;
      end
      ST_RRESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr0_q;
    ram_wdata = 8'h00;
    case (state_q)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_ptr_q;
      end
      ST_RD0: begin
        ram_en = 1'b1;
      end
      ST_WR0: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | bits0_q;
      end
      ST_RD1: begin
        ram_en   = 1'b1;
        ram_addr = addr1_q;
      end
      ST_WR1: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = addr1_q;
        ram_wdata = ram_rdata | bits1_q;
      end
      ST_RREQ: begin
        ram_en   = 1'b1;
        ram_addr = AW'(read_idx_q);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  pmbb_ram #(
    .WIDTH (8),
    .DEPTH (FbSize)
  ) u_fb_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_ptr_q    <= '0;
      origin_col_q <= '0;
      origin_row_q <= '0;
      cols_q       <= '0;
      pages_q      <= '0;
      invert_q     <= 1'b0;
      col_cnt_q    <= '0;
      page_cnt_q   <= '0;
      active_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_ptr_q    <= clr_ptr_d;
      origin_col_q <= origin_col_d;
      origin_row_q <= origin_row_d;
      cols_q       <= cols_d;
      pages_q      <= pages_d;
      invert_q     <= invert_d;
      col_cnt_q    <= col_cnt_d;
      page_cnt_q   <= page_cnt_d;
      active_q     <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    addr0_q    <= addr0_d;
    addr1_q    <= addr1_d;
    bits0_q    <= bits0_d;
    bits1_q    <= bits1_d;
    v1_q       <= v1_d;
    read_idx_q <= read_idx_d;
    rd_ok_q    <= rd_ok_d;
  end

  assign done_o       = (state_q == ST_RRESP);
  assign read_data_o  = rd_ok_q ? ram_rdata : 8'h00;
  assign echo_index_o = read_idx_q;

endmodule

>>> hdl/pmbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page mode bitmap blitter checker
// Port level assertions on request handling and result timing.
// ----------------------------------------------------------------------------
module pmbb_checker
  import pmbb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type_i,
  input logic [9:0] read_index_i,
  input logic       done_o,
  input logic [9:0] echo_index_o
);

  logic acc_read;
  logic acc_clear;

  assign acc_read  = start && !busy && (req_type_i == REQ_READ);
  assign acc_clear = start && !busy && (req_type_i == REQ_CLEAR);

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_read |-> ##2 (done_o && (echo_index_o == $past(read_index_i, 2))))
    else $error("Read word did not return its result two cycles after accept.");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_read |=> busy)
    else $error("Busy not raised after a read was accepted.");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_clear |=> busy)
    else $error("Busy not raised after a clear was accepted.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

endmodule

bind page_mode_bitmap_blitter pmbb_checker u_pmbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_type_i   (req_type_i),
  .read_index_i (read_index_i),
  .done_o       (done_o),
  .echo_index_o (echo_index_o)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page mode bitmap blitter testbench
// Drives clear, start blit, bitmap word and read requests through the
// start/busy handshake. A shadow framebuffer in the bench predicts every read
// result, and each result is compared with the oldest outstanding read.
// ----------------------------------------------------------------------------
module tb_top;
  import pmbb_pkg::*;

  localparam int FB_BYTES    = PMBB_COLUMNS * PMBB_PAGES;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]        req;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [7:0]        w;
    logic [7:0]        h;
    logic              inv;
    logic [7:0]        data;
    logic [9:0]        idx;
  } fb_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [9:0] idx;
  } fb_read_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic [1:0]        req_type_i   = REQ_CLEAR;
  logic signed [8:0] pos_x_i      = '0;
  logic signed [8:0] pos_y_i      = '0;
  logic [7:0]        bmp_width_i  = '0;
  logic [7:0]        bmp_height_i = '0;
  logic              invert_i     = 1'b0;
  logic [7:0]        src_byte_i   = '0;
  logic [9:0]        read_index_i = '0;
  logic              busy;
  logic              done_o;
  logic [7:0]        read_data_o;
  logic [9:0]        echo_index_o;

  page_mode_bitmap_blitter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .bmp_width_i  (bmp_width_i),
    .bmp_height_i (bmp_height_i),
    .invert_i     (invert_i),
    .src_byte_i   (src_byte_i),
    .read_index_i (read_index_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .echo_index_o (echo_index_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fb_req_t    req_backlog[$];
  fb_read_t   reads_due[$];
  fb_req_t    cur_req = '0;
  int         gap_pct = 11;
  int         n_pushed = 0;
  int         n_taken = 0;
  int         n_clears = 0;
  int         n_blits = 0;
  int         n_placed = 0;
  int         n_reads_ok = 0;
  int         n_errors = 0;
  int         stall_run = 0;

  logic [7:0] shadow_fb [0:FB_BYTES-1];
  int         blit_x0 = 0;
  int         blit_y0 = 0;
  int         blit_w = 0;
  int         blit_np = 0;
  logic       blit_inv = 1'b0;
  int         blit_col = 0;
  int         blit_pg = 0;
  logic       blit_on = 1'b0;

  function automatic void or_into_fb(input int col, input int pg, input logic [7:0] bits);
    if (col >= 0 && col < PMBB_COLUMNS && pg >= 0 && pg < PMBB_PAGES)
      shadow_fb[pg * PMBB_COLUMNS + col] |= bits;
  endfunction

  task automatic shadow_apply(input fb_req_t r);
    logic [7:0]  b;
    logic [7:0]  lo;
    int          row;
    int          biased;
    int          pg;
    int unsigned off;
    fb_read_t    rd_exp;
    case (r.req)
      REQ_CLEAR: begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
        n_clears++;
      end
      REQ_BLIT: begin
        blit_x0  = r.x;
        blit_y0  = r.y;
        blit_w   = r.w;
        blit_np  = r.h >> 3;
        blit_inv = r.inv;
        blit_col = 0;
        blit_pg  = 0;
        blit_on  = (blit_w != 0) && (blit_np != 0);
        n_blits++;
      end
      REQ_BYTE: begin
        if (blit_on) begin
          b      = blit_inv ? (r.data ^ 8'hff) : r.data;
          row    = blit_y0 + 8 * blit_pg;
          biased = row + 512;
          pg     = (biased >> 3) - 64;
          off    = biased & 7;
          lo     = b << off;
          or_into_fb(blit_x0 + blit_col, pg, lo);
          if (off != 0) or_into_fb(blit_x0 + blit_col, pg + 1, b >> (8 - off));
          n_placed++;
          blit_col++;
          if (blit_col >= blit_w) begin
            blit_col = 0;
            blit_pg++;
            if (blit_pg >= blit_np) begin
              blit_pg = 0;
              blit_on = 1'b0;
            end
          end
        end
      end
      default: begin
        rd_exp.idx  = r.idx;
        rd_exp.data = (r.idx < FB_BYTES) ? shadow_fb[r.idx] : 8'h00;
        reads_due.push_back(rd_exp);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fb_req_t nxt;
    logic    go;
    if (!rst_ni) begin
      start        <= 1'b0;
      cur_req      <= '0;
      req_type_i   <= REQ_CLEAR;
      pos_x_i      <= '0;
      pos_y_i      <= '0;
      bmp_width_i  <= '0;
      bmp_height_i <= '0;
      invert_i     <= 1'b0;
      src_byte_i   <= '0;
      read_index_i <= '0;
    end else begin
      go  = start;
      nxt = cur_req;
      if (start && !busy) begin
        shadow_apply(cur_req);
        n_taken++;
        go = 1'b0;
      end
      if (!go && req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = req_backlog.pop_front();
        go  = 1'b1;
      end
      start        <= go;
      cur_req      <= nxt;
      req_type_i   <= nxt.req;
      pos_x_i      <= nxt.x;
      pos_y_i      <= nxt.y;
      bmp_width_i  <= nxt.w;
      bmp_height_i <= nxt.h;
      invert_i     <= nxt.inv;
      src_byte_i   <= nxt.data;
      read_index_i <= nxt.idx;
    end
  end

  always @(posedge clk_i) begin
    fb_read_t want;
    if (rst_ni && done_o) begin
      if (reads_due.size() == 0) begin
        $error("unexpected read result: index %0d, data %02h", echo_index_o, read_data_o);
        n_errors++;
      end else begin
        want = reads_due.pop_front();
        if (read_data_o !== want.data) begin
          $error("read_data: expected %02h, actual %02h", want.data, read_data_o);
          n_errors++;
        end
        if (echo_index_o !== want.idx) begin
          $error("echo_index: expected %0d, actual %0d", want.idx, echo_index_o);
          n_errors++;
        end
        n_reads_ok++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) stall_run <= 0;
    else stall_run <= stall_run + 1;
    if (stall_run >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic fb_req_t rand_req();
    fb_req_t r;
    r.req  = 2'($urandom_range(3));
    r.x    = 9'(int'($urandom_range(382)) - 255);
    r.y    = 9'(int'($urandom_range(318)) - 255);
    r.w    = 8'($urandom_range(255));
    r.h    = 8'($urandom_range(255));
    r.inv  = 1'($urandom_range(1));
    r.data = 8'($urandom_range(255));
    r.idx  = 10'($urandom_range(1023));
    return r;
  endfunction

  task automatic push_req(input fb_req_t r);
    req_backlog.push_back(r);
    n_pushed++;
  endtask

  task automatic clr();
    fb_req_t r;
    r     = rand_req();
    r.req = REQ_CLEAR;
    push_req(r);
  endtask

  task automatic blit(input int x, input int y, input int w, input int h, input bit inv);
    fb_req_t r;
    r     = rand_req();
    r.req = REQ_BLIT;
    r.x   = 9'(x);
    r.y   = 9'(y);
    r.w   = 8'(w);
    r.h   = 8'(h);
    r.inv = inv;
    push_req(r);
  endtask

  task automatic bmp(input logic [7:0] b);
    fb_req_t r;
    r      = rand_req();
    r.req  = REQ_BYTE;
    r.data = b;
    push_req(r);
  endtask

  task automatic rd(input int idx);
    fb_req_t r;
    r     = rand_req();
    r.req = REQ_READ;
    r.idx = 10'(idx);
    push_req(r);
  endtask

  task automatic queue_traffic(input int n);
    int target;
    int sel;
    int x;
    int y;
    int w;
    int np;
    int nbytes;
    int col;
    int pg;
    bit big_blit;
    fb_req_t r;
    target = n_pushed + n;
    while (n_pushed < target) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        big_blit = ($urandom_range(19) == 0);
        if ($urandom_range(9) == 0) begin
          x = int'($urandom_range(382)) - 255;
          y = int'($urandom_range(318)) - 255;
        end else begin
          x = int'($urandom_range(143)) - 16;
          y = int'($urandom_range(79)) - 16;
        end
        w  = big_blit ? $urandom_range(255) : $urandom_range(12, 1);
        np = big_blit ? $urandom_range(31) : $urandom_range(4, 1);
        blit(x, y, w, np * 8 + $urandom_range(7), $urandom_range(1));
        nbytes = w * np;
        if (big_blit || $urandom_range(9) == 0)
          nbytes = $urandom_range(nbytes < 40 ? nbytes : 40);
        for (int k = 0; k < nbytes; k++) begin
          bmp($urandom_range(255));
          if ($urandom_range(6) == 0) rd($urandom_range(1023));
        end
        repeat ($urandom_range(3, 1)) begin
          col = x + ((w == 0) ? 0 : int'($urandom_range(w - 1)));
          pg  = ((y + 512) >> 3) - 64 + int'($urandom_range(np));
          if (col >= 0 && col < PMBB_COLUMNS && pg >= 0 && pg < PMBB_PAGES)
            rd(pg * PMBB_COLUMNS + col);
          else
            rd($urandom_range(1023));
        end
      end else if (sel < 85) begin
        repeat ($urandom_range(4, 1)) rd($urandom_range(1023));
      end else if (sel < 89) begin
        clr();
      end else begin
        r = rand_req();
        if (r.req == REQ_CLEAR) r.req = REQ_BYTE;
        push_req(r);
        target++;
      end
    end
  endtask

  task automatic drain();
    while (n_taken != n_pushed || reads_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct = 11;
    rd(0);
    rd(FB_BYTES - 1);
    bmp(8'hff);
    blit(0, 0, 2, 8, 1'b0);
    bmp(8'hff);
    bmp(8'h01);
    rd(0);
    rd(1);
    blit(127, 63, 1, 8, 1'b1);
    bmp(8'h00);
    rd(FB_BYTES - 1);
    blit(-255, -255, 255, 255, 1'b1);
    bmp(8'ha5);
    blit(10, 5, 0, 255, 1'b0);
    bmp(8'h3c);
    blit(10, 5, 5, 7, 1'b0);
    bmp(8'h3c);
    blit(-1, -3, 3, 16, 1'b0);
    bmp(8'h81);
    bmp(8'h7e);
    clr();
    bmp(8'hff);
    bmp(8'hff);
    rd(1);
    rd(PMBB_COLUMNS + 1);
    queue_traffic(400);
    drain();

    gap_pct = 51;
    queue_traffic(400);
    drain();

    gap_pct = 0;
    queue_traffic(350);
    drain();

    repeat (20) @(posedge clk_i);
    $display("Ran %0d requests: %0d clears, %0d blit starts, %0d placed bitmap words.",
             n_taken, n_clears, n_blits, n_placed);
    $display("Checked %0d read results against the shadow framebuffer, %0d errors.",
             n_reads_ok, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
